// ===== rtl/life_grid_neighbour_count_engine_assert.svh =====
// Assertion macros used by the grid engine's port-level checker.
`ifndef LIFE_GRID_NEIGHBOUR_COUNT_ENGINE_ASSERT_SVH
`define LIFE_GRID_NEIGHBOUR_COUNT_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define LGNC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define LGNC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lgnc_pkg.sv =====
// Shared types and constants of the life grid neighbour count engine.
package lgnc_pkg;

    localparam int CFG_W     = 7;
    localparam int DIM_MIN   = 3;
    localparam int DIM_RESET = 64;

    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_STEP  = 2'd3;

    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    typedef struct packed {
        logic [1:0] opcode;
        logic [5:0] col;
        logic [5:0] row;
    } lgnc_in_t;

    typedef struct packed {
        logic       alive;
        logic [3:0] neighbours;
    } lgnc_out_t;

    // Three vertically adjacent live bits held by one column cell.
    typedef struct packed {
        logic above;
        logic own;
        logic below;
    } lgnc_win_t;

endpackage

// ===== rtl/lgnc_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module lgnc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lgnc_cell.sv =====
// One column cell: a three-row window of live bits and its Conway rule.
module lgnc_cell (
    input  logic              aclk,
    input  logic              shift_en,
    input  logic              shift_bit,
    input  lgnc_pkg::lgnc_win_t left_win,
    input  lgnc_pkg::lgnc_win_t right_win,
    output lgnc_pkg::lgnc_win_t win,
    output logic              next_live,
    output logic [3:0]        count
);
    import lgnc_pkg::*;

    lgnc_win_t win_reg;
    lgnc_win_t win_next;

    // rows move up one place per shift; new row enters at the bottom
    always_comb begin
        win_next.above = win_reg.own;
        win_next.own   = win_reg.below;
        win_next.below = shift_bit;
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            win_reg <= win_next;
        end
    end

    always_comb begin
        count = 4'(left_win.above) + 4'(left_win.own) + 4'(left_win.below)
              + 4'(right_win.above) + 4'(right_win.own) + 4'(right_win.below)
              + 4'(win_reg.above) + 4'(win_reg.below);
        if (win_reg.own) begin
            next_live = (count == 4'd2) || (count == 4'd3);
        end else begin
            next_live = (count == 4'd3);
        end
    end

    assign win = win_reg;

endmodule

// ===== rtl/life_grid_neighbour_count_engine.sv =====
// Toroidal life grid: live bits in a row-wide RAM, processed by a row of column cells.
// Set/clear/read: three row reads (above, own, below) fill the cell window before the result.
// Generation step: one row read and one row write per cycle, the RAM port pair sets the pace.
// Address outside the grid: no row reads, the result is issued from ST_FIN.
// Reset (aresetn low, synchronous) and every cols/rows write start a clearing pass over all
// MAX_ROWS rows, one row per cycle, during which s_ready stays low.
module life_grid_neighbour_count_engine #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  lgnc_pkg::lgnc_in_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output lgnc_pkg::lgnc_out_t           m_data,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [lgnc_pkg::CFG_W-1:0]    cfg_data
);
    import lgnc_pkg::*;

    localparam int CAW = $clog2(MAX_COLS);
    localparam int RAW = $clog2(MAX_ROWS);
    localparam int CW  = $clog2(MAX_COLS + 1);
    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int KW  = $clog2(MAX_ROWS + 3);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int hi);
        int vi;
        vi = int'(v);
        if (vi < DIM_MIN) return DIM_MIN;
        if (vi > hi) return hi;
        return vi;
    endfunction

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    logic [2:0]          state_reg,     state_next;
    logic [CW-1:0]       cols_reg,      cols_next;
    logic [RW-1:0]       rows_reg,      rows_next;
    logic [RAW-1:0]      clr_cnt_reg,   clr_cnt_next;
    logic [1:0]          op_reg,        op_next;
    logic [CAW-1:0]      col_idx_reg,   col_idx_next;
    logic [RAW-1:0]      row_idx_reg,   row_idx_next;
    logic [KW-1:0]       icnt_reg,      icnt_next;
    logic [KW-1:0]       scnt_reg,      scnt_next;
    logic                pend_reg,      pend_next;
    logic                pend_sv_reg,   pend_sv_next;
    logic                win_reg,       win_next;
    logic                win_last_reg,  win_last_next;
    logic [RAW-1:0]      wr_row_reg,    wr_row_next;
    logic [MAX_COLS-1:0] saved_row_reg;
    lgnc_out_t           res_reg,       res_next;
    logic                m_valid_reg,   m_valid_next;
    lgnc_out_t           m_data_reg,    m_data_next;

    // ---------------------------------------------------------------
    // Datapath signals
    // ---------------------------------------------------------------
    logic                ram_we;
    logic [RAW-1:0]      ram_waddr;
    logic [MAX_COLS-1:0] ram_wdata;
    logic [RAW-1:0]      ram_raddr;
    logic [MAX_COLS-1:0] ram_rdata;
    logic [MAX_COLS-1:0] shift_row;
    logic [MAX_COLS-1:0] own_row;
    logic [MAX_COLS-1:0] gen_row;
    logic [MAX_COLS-1:0] cell_row;
    lgnc_win_t           col_win  [MAX_COLS];
    logic [3:0]          col_cnt  [MAX_COLS];
    logic [MAX_COLS-1:0] col_next;
    lgnc_win_t           last_win;

    logic                is_gen;
    logic [KW-1:0]       last_k;
    logic                issue_saved;
    logic                out_free;
    logic                in_range;
    logic                cur_bit;
    logic                new_bit;
    logic [RAW-1:0]      above_row;
    logic [RAW-1:0]      below_row;

    assign is_gen   = (op_reg == OP_STEP);
    assign last_k   = is_gen ? (KW'(rows_reg) + KW'(1)) : KW'(2);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign in_range = (int'(s_data.col) < int'(cols_reg)) && (int'(s_data.row) < int'(rows_reg));

    // row store: one RAM word per grid row, one bit per column
    lgnc_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // the row after the last on a step is row 0 as it was before the step
    assign shift_row = pend_sv_reg ? saved_row_reg : ram_rdata;

    // ---------------------------------------------------------------
    // Row of column cells, wrapping at the cols boundary
    // ---------------------------------------------------------------
    assign last_win = col_win[CAW'(cols_reg - CW'(1))];

    for (genvar c = 0; c < MAX_COLS; c++) begin : g_cell
        lgnc_win_t left_w;
        lgnc_win_t right_w;

        if (c == 0) begin : g_left_wrap
            assign left_w = last_win;
        end else begin : g_left
            assign left_w = col_win[c-1];
        end

        if (c == MAX_COLS - 1) begin : g_right_wrap
            assign right_w = col_win[0];
        end else begin : g_right
            assign right_w = (int'(cols_reg) == c + 1) ? col_win[0] : col_win[c+1];
        end

        lgnc_cell u_cell (
            .aclk      (aclk),
            .shift_en  (pend_reg),
            .shift_bit (shift_row[c]),
            .left_win  (left_w),
            .right_win (right_w),
            .win       (col_win[c]),
            .next_live (col_next[c]),
            .count     (col_cnt[c])
        );

        assign own_row[c] = col_win[c].own;
        // columns beyond the grid in use stay dead
        assign gen_row[c] = (c < int'(cols_reg)) ? col_next[c] : 1'b0;
    end

    // ---------------------------------------------------------------
    // Single-cell operation: new live bit and row to write back
    // ---------------------------------------------------------------
    always_comb begin
        cur_bit = own_row[col_idx_reg];
        unique case (op_reg)
            OP_SET:   new_bit = 1'b1;
            OP_CLEAR: new_bit = 1'b0;
            default:  new_bit = cur_bit;
        endcase
        cell_row              = own_row;
        cell_row[col_idx_reg] = new_bit;
    end

    assign above_row = (row_idx_reg == '0) ? RAW'(rows_reg - RW'(1)) : row_idx_reg - RAW'(1);
    assign below_row = (RW'(row_idx_reg) + RW'(1) == rows_reg) ? '0 : row_idx_reg + RAW'(1);

    // read address: three rows for a cell op, rows-1, 0 .. rows-1 for a step
    always_comb begin
        issue_saved = is_gen && (icnt_reg == last_k);
        if (is_gen) begin
            if (icnt_reg == '0) begin
                ram_raddr = RAW'(rows_reg - RW'(1));
            end else begin
                ram_raddr = RAW'(icnt_reg - KW'(1));
            end
        end else begin
            priority if (icnt_reg == '0) begin
                ram_raddr = above_row;
            end else if (icnt_reg == KW'(1)) begin
                ram_raddr = row_idx_reg;
            end else begin
                ram_raddr = below_row;
            end
        end
    end

    // write port: clearing pass, step row write-back, or cell write-back
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = clr_cnt_reg;
        ram_wdata = '0;
        if (state_reg == ST_CLEAR) begin
            ram_we = 1'b1;
        end else if (win_reg && is_gen) begin
            ram_we    = 1'b1;
            ram_waddr = wr_row_reg;
            ram_wdata = gen_row;
        end else if (win_reg && (op_reg != OP_READ)) begin
            ram_we    = 1'b1;
            ram_waddr = row_idx_reg;
            ram_wdata = cell_row;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        cols_next     = cols_reg;
        rows_next     = rows_reg;
        clr_cnt_next  = clr_cnt_reg;
        op_next       = op_reg;
        col_idx_next  = col_idx_reg;
        row_idx_next  = row_idx_reg;
        icnt_next     = icnt_reg;
        scnt_next     = scnt_reg;
        pend_next     = 1'b0;
        pend_sv_next  = 1'b0;
        res_next      = res_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        // window tracking: a shift completes a window once two rows are in
        win_next      = pend_reg && (is_gen ? (scnt_reg >= KW'(2)) : (scnt_reg == KW'(2)));
        win_last_next = pend_reg && (scnt_reg == last_k);
        wr_row_next   = RAW'(scnt_reg - KW'(2));
        if (pend_reg) begin
            scnt_next = scnt_reg + KW'(1);
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next      = s_data.opcode;
                    col_idx_next = CAW'(s_data.col);
                    row_idx_next = RAW'(s_data.row);
                    icnt_next    = '0;
                    scnt_next    = '0;
                    res_next     = '0;
                    if ((s_data.opcode == OP_STEP) || in_range) begin
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + RAW'(1);
                if (clr_cnt_reg == RAW'(MAX_ROWS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD: begin
                pend_next    = 1'b1;
                pend_sv_next = issue_saved;
                icnt_next    = icnt_reg + KW'(1);
                if (icnt_reg == last_k) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (win_reg && win_last_reg) begin
                    if (!is_gen) begin
                        res_next.alive      = new_bit;
                        res_next.neighbours = col_cnt[col_idx_reg];
                    end
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // geometry change rebuilds an empty grid
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_COLS: cols_next = CW'(clamp_dim(cfg_data, MAX_COLS));
                CFG_ROWS: rows_next = RW'(clamp_dim(cfg_data, MAX_ROWS));
                default:  ;
            endcase
            state_next   = ST_CLEAR;
            clr_cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            cols_reg     <= CW'(clamp_dim(CFG_W'(DIM_RESET), MAX_COLS));
            rows_reg     <= RW'(clamp_dim(CFG_W'(DIM_RESET), MAX_ROWS));
            pend_reg     <= 1'b0;
            pend_sv_reg  <= 1'b0;
            win_reg      <= 1'b0;
            win_last_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            op_reg       <= OP_READ;
            icnt_reg     <= '0;
            scnt_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            cols_reg     <= cols_next;
            rows_reg     <= rows_next;
            pend_reg     <= pend_next;
            pend_sv_reg  <= pend_sv_next;
            win_reg      <= win_next;
            win_last_reg <= win_last_next;
            m_valid_reg  <= m_valid_next;
            op_reg       <= op_next;
            icnt_reg     <= icnt_next;
            scnt_reg     <= scnt_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        col_idx_reg <= col_idx_next;
        row_idx_reg <= row_idx_next;
        wr_row_reg  <= wr_row_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
        if (pend_reg && is_gen && (scnt_reg == KW'(1))) begin
            saved_row_reg <= ram_rdata;
        end
    end

endmodule

// ===== rtl/lgnc_checker.sv =====
// Port-level checker for the life grid engine, bound to the top level.
`include "life_grid_neighbour_count_engine_assert.svh"

module lgnc_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input lgnc_pkg::lgnc_out_t        m_data,
    input logic                       cfg_we
);

    `LGNC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result dropped")
    `LGNC_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "took two transactions")
    `LGNC_ASSERT_NEXT(a_clear_after_cfg, cfg_we, !s_ready, "no clearing pass after config write")
    `LGNC_ASSERT_NOW(a_count_range, m_valid, m_data.neighbours <= 4'd8, "neighbour count above 8")

endmodule

bind life_grid_neighbour_count_engine lgnc_checker u_lgnc_checker (.*);

// ===== sim/lgnc_checker.sv =====
// Scoreboard for the life grid engine: predicts each transaction's result and compares.
module lgnc_scoreboard
    import lgnc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  lgnc_in_t            s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  lgnc_out_t           m_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    output int                  pending,
    output int                  errors
);

    localparam int GRID_W = 64;
    localparam int GRID_H = 64;

    // bit 0 live, bits 4:1 neighbour count
    logic [4:0] life_grid [GRID_W*GRID_H];
    logic [4:0] frozen_grid [GRID_W*GRID_H];
    int unsigned grid_cols;
    int unsigned grid_rows;
    lgnc_out_t   result_q [$];

    function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned hi);
        if (v < DIM_MIN) return DIM_MIN;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void adjust_count(int unsigned c, int unsigned r, bit up);
        logic [3:0] cnt;
        cnt = life_grid[r*GRID_W + c][4:1];
        cnt = up ? cnt + 4'd1 : cnt - 4'd1;
        life_grid[r*GRID_W + c][4:1] = cnt;
    endfunction

    function automatic void toggle_cell(int unsigned c, int unsigned r, bit make_live);
        int unsigned lf, rt, up, dn;
        if (life_grid[r*GRID_W + c][0] == make_live) return;
        life_grid[r*GRID_W + c][0] = make_live;
        lf = (c == 0) ? grid_cols - 1 : c - 1;
        rt = (c + 1 >= grid_cols) ? 0 : c + 1;
        up = (r == 0) ? grid_rows - 1 : r - 1;
        dn = (r + 1 >= grid_rows) ? 0 : r + 1;
        adjust_count(lf, up, make_live);
        adjust_count(c,  up, make_live);
        adjust_count(rt, up, make_live);
        adjust_count(lf, r,  make_live);
        adjust_count(rt, r,  make_live);
        adjust_count(lf, dn, make_live);
        adjust_count(c,  dn, make_live);
        adjust_count(rt, dn, make_live);
    endfunction

    function automatic void advance_generation();
        logic [4:0] v;
        for (int i = 0; i < GRID_W*GRID_H; i++) frozen_grid[i] = life_grid[i];
        for (int unsigned r = 0; r < grid_rows; r++) begin
            for (int unsigned c = 0; c < grid_cols; c++) begin
                v = frozen_grid[r*GRID_W + c];
                if (v[0]) begin
                    if (v[4:1] != 4'd2 && v[4:1] != 4'd3) toggle_cell(c, r, 1'b0);
                end else if (v[4:1] == 4'd3) begin
                    toggle_cell(c, r, 1'b1);
                end
            end
        end
    endfunction

    function automatic lgnc_out_t predict_cell(lgnc_in_t t);
        lgnc_out_t res;
        logic [4:0] v;
        res = '0;
        if (t.opcode == OP_STEP) begin
            advance_generation();
            return res;
        end
        if (t.col >= grid_cols || t.row >= grid_rows) return res;
        if (t.opcode == OP_SET) toggle_cell(t.col, t.row, 1'b1);
        else if (t.opcode == OP_CLEAR) toggle_cell(t.col, t.row, 1'b0);
        v = life_grid[t.row*GRID_W + t.col];
        res.alive = v[0];
        res.neighbours = v[4:1];
        return res;
    endfunction

    function automatic void wipe_grid();
        for (int i = 0; i < GRID_W*GRID_H; i++) life_grid[i] = '0;
    endfunction

    initial begin
        pending = 0;
        errors = 0;
    end

    always @(posedge aclk) begin
        lgnc_out_t want;
        if (!aresetn) begin
            wipe_grid();
            grid_cols = DIM_RESET;
            grid_rows = DIM_RESET;
            result_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_COLS) grid_cols = clamp_dim(cfg_data, GRID_W);
                else grid_rows = clamp_dim(cfg_data, GRID_H);
                wipe_grid();
            end
            if (s_valid && s_ready) begin
                result_q.push_back(predict_cell(s_data));
            end
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result alive=%0d neighbours=%0d", $time,
                             m_data.alive, m_data.neighbours);
                    errors <= errors + 1;
                end else begin
                    want = result_q.pop_front();
                    if (want.alive !== m_data.alive || want.neighbours !== m_data.neighbours) begin
                        $display({"%0t: mismatch expected alive=%0d neighbours=%0d, ",
                                  "got alive=%0d neighbours=%0d"},
                                 $time, want.alive, want.neighbours, m_data.alive,
                                 m_data.neighbours);
                        errors <= errors + 1;
                    end
                end
            end
        end
        pending <= result_q.size();
    end

endmodule

// ===== sim/tb.sv =====
// Top of the life grid engine testbench: stimulus, idling phases and verdict.
module tb;
    import lgnc_pkg::*;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    lgnc_in_t           s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    lgnc_out_t          m_data;
    logic               cfg_we = 1'b0;
    logic               cfg_index = CFG_COLS;
    logic [CFG_W-1:0]   cfg_data = '0;

    int pending;
    int errors;

    // idling percentages for the current phase
    int unsigned send_gap_pct = 0;
    int unsigned sink_stall_pct = 0;
    logic        long_hold_req = 1'b0;

    int unsigned cur_cols = DIM_RESET;
    int unsigned cur_rows = DIM_RESET;
    int          sent_total = 0;
    int          step_total = 0;
    int          quiet_cycles = 0;

    life_grid_neighbour_count_engine dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    lgnc_scoreboard scoreboard (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pending(pending), .errors(errors)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Result side: random stalls, plus one long hold-off that it times itself.
    initial begin
        int  hold_left;
        bit  hold_taken;
        hold_left = 0;
        hold_taken = 0;
        forever begin
            @(posedge aclk);
            if (long_hold_req && !hold_taken) begin
                hold_taken = 1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Watchdog: ends the run if no transaction moves for too long.
    initial begin
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= 5000) begin
                $display("%0t: watchdog expired, %0d results outstanding", $time, pending);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Offer one transaction; valid stays up into the next call if no gap is drawn.
    task automatic send_cmd(logic [1:0] op, logic [5:0] c, logic [5:0] r);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{opcode: op, col: c, row: r};
        do @(posedge aclk); while (!s_ready);
        sent_total++;
        if (op == OP_STEP) step_total++;
    endtask

    // Drain everything, allow the block to settle, then write one register.
    task automatic write_dim(logic idx, logic [CFG_W-1:0] val);
        s_valid <= 1'b0;
        // so the pending count includes a transaction taken at the last edge
        @(posedge aclk);
        wait (pending == 0);
        repeat (100) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_COLS) cur_cols = (val < DIM_MIN) ? DIM_MIN : (val > 64) ? 64 : val;
        else cur_rows = (val < DIM_MIN) ? DIM_MIN : (val > 64) ? 64 : val;
    endtask

    // Mostly in-grid work on the current geometry, some stray addresses.
    task automatic random_burst(int count);
        int unsigned pick;
        logic [1:0]  op;
        logic [5:0]  c, r;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 35) op = OP_SET;
            else if (pick < 55) op = OP_CLEAR;
            else if (pick < 82) op = OP_READ;
            else op = OP_STEP;
            if ($urandom_range(9) == 0 || op == OP_STEP) begin
                c = 6'($urandom);
                r = 6'($urandom);
            end else begin
                c = 6'($urandom_range(cur_cols - 1));
                r = 6'($urandom_range(cur_rows - 1));
            end
            send_cmd(op, c, r);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: full 64x64 grid, wrap at every edge, no-op set/clear.
        send_cmd(OP_SET,   6'd0,  6'd0);
        send_cmd(OP_READ,  6'd63, 6'd63);
        send_cmd(OP_READ,  6'd1,  6'd1);
        send_cmd(OP_SET,   6'd63, 6'd63);
        send_cmd(OP_READ,  6'd0,  6'd0);
        send_cmd(OP_SET,   6'd0,  6'd0);
        send_cmd(OP_CLEAR, 6'd21, 6'd42);
        send_cmd(OP_CLEAR, 6'd63, 6'd63);
        send_cmd(OP_READ,  6'd63, 6'd0);
        // blinker across the top edge, then step twice
        send_cmd(OP_SET,   6'd10, 6'd63);
        send_cmd(OP_SET,   6'd10, 6'd0);
        send_cmd(OP_SET,   6'd10, 6'd1);
        send_cmd(OP_STEP,  6'd63, 6'd63);
        send_cmd(OP_READ,  6'd9,  6'd0);
        send_cmd(OP_STEP,  6'd0,  6'd0);
        send_cmd(OP_READ,  6'd10, 6'd63);

        // Below-minimum write saturates to 3; tiny grid with stray addresses.
        write_dim(CFG_COLS, 7'd0);
        write_dim(CFG_ROWS, 7'd3);
        send_cmd(OP_SET,   6'd0,  6'd0);
        send_cmd(OP_SET,   6'd2,  6'd2);
        send_cmd(OP_READ,  6'd1,  6'd1);
        send_cmd(OP_SET,   6'd40, 6'd1);
        send_cmd(OP_READ,  6'd1,  6'd63);
        send_cmd(OP_STEP,  6'd5,  6'd5);
        send_cmd(OP_READ,  6'd0,  6'd0);

        // Phase A: no idling, 8x6 grid, above-maximum rows saturates later.
        write_dim(CFG_COLS, 7'd8);
        write_dim(CFG_ROWS, 7'd6);
        random_burst(25);

        // Phase B: sender idles often, saturated height.
        write_dim(CFG_COLS, 7'd5);
        write_dim(CFG_ROWS, 7'd127);
        send_gap_pct = 57;
        random_burst(25);

        // Phase C: receiver stalls often; long hold-off with a flood of reads.
        write_dim(CFG_COLS, 7'd12);
        write_dim(CFG_ROWS, 7'd10);
        send_gap_pct = 0;
        sink_stall_pct = 57;
        random_burst(10);
        long_hold_req <= 1'b1;
        for (int i = 0; i < 20; i++)
            send_cmd(OP_READ, 6'($urandom_range(11)), 6'($urandom_range(9)));
        random_burst(15);

        // Phase D: both sides idle a little, largest grid.
        write_dim(CFG_COLS, 7'd64);
        write_dim(CFG_ROWS, 7'd64);
        send_gap_pct = 15;
        sink_stall_pct = 15;
        random_burst(30);

        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (100) @(posedge aclk);

        $display("Covered %0d transactions (%0d generation steps) over grids from 3x3 to 64x64,",
                 sent_total, step_total);
        $display("with wraparound, stray addresses, saturating geometry and four idling mixes.");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
